### design/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned OperandBitsDef = 16;
  localparam int unsigned FieldBits      = 16;
  localparam int unsigned NumBits        = 33;
  localparam int unsigned DenBits        = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic signed [FieldBits-1:0] num_a;
    logic signed [FieldBits-1:0] den_a;
    logic signed [FieldBits-1:0] num_b;
    logic signed [FieldBits-1:0] den_b;
  } in_t;

  typedef struct packed {
    logic signed [NumBits-1:0] res_num;
    logic signed [DenBits-1:0] res_den;
    logic                      reduce_fault;
  } out_t;

  // item as handed from the front to the back
  typedef struct packed {
    in_t  item;
    logic needs_reduce;
  } job_t;

endpackage

### design/rau_queue.sv
`timescale 1ns / 1ps
module rau_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rau_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rau_pkg::job_t head_o
);

  rau_pkg::job_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/rau_front.sv
`timescale 1ns / 1ps
module rau_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rau_pkg::in_t  in_item_i,
  output logic          push_o,
  output rau_pkg::job_t push_data_o,
  input  logic          q_full_i
);

  logic          valid_q, valid_d;
  rau_pkg::job_t job_q, job_d;
  logic          accept;

  assign in_stall_o  = valid_q & q_full_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign push_o      = valid_q & ~q_full_i;
  assign push_data_o = job_q;

  always_comb begin
    valid_d = accept | (valid_q & ~push_o);
    job_d   = job_q;
    if (accept) begin
      job_d.item         = in_item_i;
      job_d.needs_reduce = (in_item_i.op == rau_pkg::OP_ADD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

### design/rau_back.sv
`timescale 1ns / 1ps
module rau_back #(
  parameter int unsigned OPERAND_BITS = rau_pkg::OperandBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rau_pkg::job_t q_head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rau_pkg::out_t out_item_o
);

  localparam int unsigned W  = OPERAND_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned KW = $clog2(SW + 1);
  localparam int unsigned NW = (SW > rau_pkg::NumBits) ? SW : rau_pkg::NumBits;
  localparam int unsigned DW = (PW > rau_pkg::DenBits) ? PW : rau_pkg::DenBits;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_e;

  state_e                 state_q;
  rau_pkg::op_e           op_q;
  logic                   reduce_q;
  logic signed [W-1:0]    na_q, da_q, nb_q, db_q;
  logic signed [PW-1:0]   p0_q, p1_q, p2_q;
  logic signed [SW-1:0]   rn_q;
  logic signed [PW-1:0]   rd_q;
  logic                   fault_q;
  logic                   n_neg_q, d_neg_q;
  logic [SW-1:0]          x_q, y_q, dmag_q, g_q, quo_q, rem_q;
  logic [KW-1:0]          k_q, cnt_q;
  logic                   out_valid_q;
  rau_pkg::out_t          out_q;

  logic signed [W-1:0]    ma, mb;
  logic signed [PW-1:0]   prod;
  logic signed [SW-1:0]   n_sum, d_ext;
  logic [SW:0]            r2;
  logic                   r2_ge;
  logic [SW-1:0]          quo_next, rem_next, neg_quo;
  logic                   out_free;
  logic signed [NW-1:0]   rn_w;
  logic signed [DW-1:0]   rd_w;

  function automatic logic signed [W-1:0] operand(input logic [rau_pkg::FieldBits-1:0] raw);
    logic [31:0] z;
    z = {16'b0, raw};
    return z[W-1:0];
  endfunction

  always_comb begin
    unique case (state_q)
      S_MUL0: begin
        ma = na_q;
        mb = (op_q == rau_pkg::OP_MUL) ? nb_q : db_q;
      end
      S_MUL1: begin
        ma = nb_q;
        mb = da_q;
      end
      default: begin
        ma = da_q;
        mb = (op_q == rau_pkg::OP_DIV) ? nb_q : db_q;
      end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    case (op_q)
      rau_pkg::OP_ADD: n_sum = SW'(p0_q) + SW'(p1_q);
      rau_pkg::OP_SUB: n_sum = SW'(p0_q) - SW'(p1_q);
      default:         n_sum = SW'(p0_q);
    endcase
    d_ext = SW'(p2_q);
  end

  always_comb begin
    r2       = {rem_q, quo_q[SW-1]};
    r2_ge    = (r2 >= {1'b0, g_q});
    rem_next = r2_ge ? SW'(r2 - {1'b0, g_q}) : r2[SW-1:0];
    quo_next = {quo_q[SW-2:0], r2_ge};
    neg_quo  = -quo_next;
  end

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign pop_o       = (state_q == S_IDLE) & ~q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign rn_w        = NW'(rn_q);
  assign rd_w        = DW'(rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            state_q <= S_MUL0;
          end
        end
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_COMB;
        S_COMB: begin
          if (reduce_q && n_sum != '0 && d_ext != '0) begin
            state_q <= S_GCD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_GCD: begin
          if (x_q == '0 || y_q == '0) begin
            state_q <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (cnt_q == '0) begin
            state_q <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q     <= q_head_i.item.op;
        reduce_q <= q_head_i.needs_reduce;
        na_q     <= operand(q_head_i.item.num_a);
        da_q     <= operand(q_head_i.item.den_a);
        nb_q     <= operand(q_head_i.item.num_b);
        db_q     <= operand(q_head_i.item.den_b);
      end
      S_MUL0: p0_q <= prod;
      S_MUL1: p1_q <= prod;
      S_MUL2: p2_q <= prod;
      S_COMB: begin
        rn_q    <= n_sum;
        rd_q    <= p2_q;
        fault_q <= reduce_q && (n_sum == '0 || d_ext == '0);
        n_neg_q <= n_sum[SW-1];
        d_neg_q <= d_ext[SW-1];
        x_q     <= n_sum[SW-1] ? -n_sum : n_sum;
        y_q     <= d_ext[SW-1] ? -d_ext : d_ext;
        dmag_q  <= d_ext[SW-1] ? -d_ext : d_ext;
        k_q     <= '0;
      end
      S_GCD: begin
        if (x_q == '0 || y_q == '0) begin
          g_q   <= (x_q | y_q) << k_q;
          quo_q <= n_neg_q ? -rn_q : rn_q;
          rem_q <= '0;
          cnt_q <= KW'(SW - 1);
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + KW'(1);
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= (x_q - y_q) >> 1;
        end else begin
          y_q <= (y_q - x_q) >> 1;
        end
      end
      S_DIVN: begin
        if (cnt_q == '0) begin
          rn_q  <= n_neg_q ? neg_quo : quo_next;
          quo_q <= dmag_q;
          rem_q <= '0;
          cnt_q <= KW'(SW - 1);
        end else begin
          quo_q <= quo_next;
          rem_q <= rem_next;
          cnt_q <= cnt_q - KW'(1);
        end
      end
      S_DIVD: begin
        if (cnt_q == '0) begin
          rd_q <= d_neg_q ? neg_quo[PW-1:0] : quo_next[PW-1:0];
        end else begin
          quo_q <= quo_next;
          rem_q <= rem_next;
          cnt_q <= cnt_q - KW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_q.res_num      <= rn_w[rau_pkg::NumBits-1:0];
          out_q.res_den      <= rd_w[rau_pkg::DenBits-1:0];
          out_q.reduce_fault <= fault_q;
        end
      end
      default: ;
    endcase
  end

endmodule

### design/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake                 | Item
// in      | in  | in_valid_i / in_stall_o   | rau_pkg::in_t  (op, num_a, den_a, num_b, den_b)
// out     | out | out_valid_o / out_stall_i | rau_pkg::out_t (res_num, res_den, reduce_fault)
// Subtract, multiply, divide: the result comes from three passes through one shared
// multiplier and is not reduced.
// Add: up to about 4*OPERAND_BITS gcd steps plus two bit-serial exact divisions of
// 2*OPERAND_BITS+1 steps each; a zero sum or denominator skips them and sets reduce_fault.
// Reset is asynchronous and empties the input register, queue and output register.
// A two-entry queue decouples input from the back end; a stalled result holds its register.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_BITS = rau_pkg::OperandBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rau_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rau_pkg::out_t out_item_o
);

  logic          push, q_full, pop, q_empty;
  rau_pkg::job_t push_data, q_head;

  rau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  rau_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  rau_back #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### test/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;

  localparam int unsigned OB = rau_pkg::OperandBitsDef;
  localparam int RandomItems = 1800;
  localparam longint CycleLimit = 2_000_000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  rau_pkg::in_t   in_item_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  rau_pkg::out_t  out_item_o;

  rational_arithmetic_unit #(.OPERAND_BITS(OB)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rau_pkg::in_t   pending_items[$];
  rau_pkg::out_t  expected_fracs[$];
  int     errors = 0;
  int     sent = 0;
  int     received = 0;
  int     add_faults = 0;
  longint cycle = 0;
  bit     calm = 1'b0;       // no idling near the end
  bit     hold_sender = 1'b0;
  int     long_hold = 0;     // receiver long stall, cycles left
  int     send_gap = 0;
  int     recv_gap = 0;

  function automatic longint sx(logic [rau_pkg::FieldBits-1:0] raw);
    logic [OB-1:0] v;
    v = raw[OB-1:0];
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic rau_pkg::out_t fraction_result(rau_pkg::in_t it);
    longint na, da, nb, db, n, d;
    longint unsigned x, y, r;
    rau_pkg::out_t o;
    na = sx(it.num_a); da = sx(it.den_a); nb = sx(it.num_b); db = sx(it.den_b);
    case (it.op)
      rau_pkg::OP_ADD: begin n = na * db + nb * da; d = da * db; end
      rau_pkg::OP_SUB: begin n = na * db - nb * da; d = da * db; end
      rau_pkg::OP_MUL: begin n = na * nb; d = da * db; end
      default: begin n = na * db; d = da * nb; end
    endcase
    o.reduce_fault = 1'b0;
    if (it.op == rau_pkg::OP_ADD) begin
      if (n == 0 || d == 0) begin
        o.reduce_fault = 1'b1;
      end else begin
        x = mag(n); y = mag(d);
        while (y != 0) begin
          r = x % y; x = y; y = r;
        end
        n = n / longint'(x);
        d = d / longint'(x);
      end
    end
    o.res_num = n[rau_pkg::NumBits-1:0];
    o.res_den = d[rau_pkg::DenBits-1:0];
    return o;
  endfunction

  function automatic logic [rau_pkg::FieldBits-1:0] rnd_operand();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return 16'(int'($urandom_range(0, 6)) - 3);
      4, 5: return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rau_pkg::in_t make_item(rau_pkg::op_e op, int na, int da, int nb, int db);
    rau_pkg::in_t it;
    it.op = op; it.num_a = 16'(na); it.den_a = 16'(da);
    it.num_b = 16'(nb); it.den_b = 16'(db);
    return it;
  endfunction

  task automatic report(string what, rau_pkg::out_t got, rau_pkg::out_t exp);
    errors++;
    $display("mismatch %s at result %0d: got %0d/%0d f%0b exp %0d/%0d f%0b", what,
             received, got.res_num, got.res_den, got.reduce_fault,
             exp.res_num, exp.res_den, exp.reduce_fault);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sent++;
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && !long_hold && $urandom_range(0, 15) == 0) begin
          send_gap <= $urandom_range(1, 10);
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_sender) begin
          in_item_i <= pending_items[0];
          expected_fracs.push_back(fraction_result(pending_items[0]));
          if (pending_items[0].op == rau_pkg::OP_ADD &&
              fraction_result(pending_items[0]).reduce_fault) add_faults++;
          void'(pending_items.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i) begin
    rau_pkg::out_t exp;
    cycle++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_fracs.size() == 0) begin
          report("unexpected result", out_item_o, '0);
        end else begin
          exp = expected_fracs.pop_front();
          if (out_item_o.res_num !== exp.res_num) report("res_num", out_item_o, exp);
          if (out_item_o.res_den !== exp.res_den) report("res_den", out_item_o, exp);
          if (out_item_o.reduce_fault !== exp.reduce_fault)
            report("reduce_fault", out_item_o, exp);
        end
        received++;
      end
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 12) == 0) begin
        recv_gap <= $urandom_range(1, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
    if (cycle > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rau_pkg::op_e op;
    rau_pkg::in_t it;
    for (int k = 0; k < 4; k++) begin
      op = rau_pkg::op_e'(k);
      pending_items.push_back(make_item(op, 1, 2, 1, 3));
      pending_items.push_back(make_item(op, -32768, -32768, -32768, -32768));
      pending_items.push_back(make_item(op, 32767, -32768, 32767, 32767));
      pending_items.push_back(make_item(op, 0, 5, 0, 7));
      pending_items.push_back(make_item(op, 3, 0, -4, 0));
    end
    pending_items.push_back(make_item(rau_pkg::OP_ADD, 1, 2, -1, 2));   // sum zero
    pending_items.push_back(make_item(rau_pkg::OP_ADD, -6, 4, 10, -8));
    pending_items.push_back(make_item(rau_pkg::OP_ADD, 32767, 1, 32767, 1));
    pending_items.push_back(make_item(rau_pkg::OP_DIV, 5, 3, 0, 9));    // divide by zero
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0);
    for (int i = 0; i < RandomItems; i++) begin
      it.op = rau_pkg::op_e'($urandom_range(0, 3));
      it.num_a = rnd_operand(); it.den_a = rnd_operand();
      it.num_b = rnd_operand(); it.den_b = rnd_operand();
      pending_items.push_back(it);
      if (i == 300) begin
        long_hold = 400;  // fills the queue while items keep coming
        wait (pending_items.size() == 0);
      end
      if (i == 700) begin
        wait (pending_items.size() == 0);
        hold_sender = 1'b1;
        wait (expected_fracs.size() == 0 && !in_valid_i);
        hold_sender = 1'b0;
      end
    end
    wait (pending_items.size() <= 150);
    calm = 1'b1;
    wait (pending_items.size() == 0 && !in_valid_i);
    wait (expected_fracs.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("ran %0d items over all four operations, %0d additions hit the zero case",
             sent, add_faults);
    $display("checked %0d results with random stalls on both sides", received);
    if (errors == 0 && expected_fracs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
